FILE: design/ctcgd_pkg.sv
`timescale 1ns / 1ps
// types, constants and constant functions of the greedy ctc text decoder
// no dependencies; used by the interfaces and the core

package ctcgd_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_THRESH
    } t_state;

    // fixed field widths
    localparam int LOGIT_W  = 16;
    localparam int CLASS_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int THRESH_W = 16;
    localparam int SUM_W    = 24;
    localparam int EXP_W    = 17;

    // exp(0) in Q1.16 and the saturation point of the Q8.16 sum
    localparam logic [EXP_W-1:0] EXP_ONE = 17'h1_0000;
    localparam logic [SUM_W-1:0] SUM_MAX = 24'hFF_FFFF;

    // e^(-1/16) in Q32, and the table index is the Q8.8 difference over 16
    localparam logic [63:0] EXP_STEP_Q32    = 64'd4034748382;
    localparam int          EXP_INDEX_SHIFT = 4;
    // entries at or past this index round to zero
    localparam int          EXP_ROM_MAX     = 256;

    // class codes and characters
    localparam logic [CLASS_W-1:0] CLASS_BLANK = 6'd0;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_ONE    = 8'h31;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;

    // rounded q32 product
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b + 64'h8000_0000;
        return prod >> 32;
    endfunction

    // exp table entry: round(65536 * e^(-idx/16)) by square and multiply
    function automatic logic [EXP_W-1:0] exp_entry(input logic [7:0] idx);
        logic [63:0] res;
        logic [63:0] base;
        logic [63:0] rnd;
        res  = 64'h1_0000_0000;
        base = EXP_STEP_Q32;
        for (int i = 0; i < 8; i++) begin
            if (idx[i]) begin
                res = mul_q32(res, base);
            end
            base = mul_q32(base, base);
        end
        rnd = (res + 64'h8000) >> 16;
        return rnd[EXP_W-1:0];
    endfunction

    // ascii character of a class
    function automatic logic [CHAR_W-1:0] char_of(input logic [CLASS_W-1:0] cls);
        logic [CHAR_W-1:0] code;
        case (cls) inside
            [6'd1:6'd26]: begin
                code = CHAR_A + ({2'b00, cls} - 8'd1);
            end
            [6'd27:6'd35]: begin
                code = CHAR_ONE + ({2'b00, cls} - 8'd27);
            end
            6'd36: begin
                code = CHAR_ZERO;
            end
            default: begin
                code = CHAR_SPACE;
            end
        endcase
        return code;
    endfunction

endpackage

FILE: design/ctcgd_in_if.sv
`timescale 1ns / 1ps
// score channel: one class logit per transaction with the start-of-text flag
// depends on ctcgd_pkg for field widths

interface ctcgd_in_if
    import ctcgd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [LOGIT_W-1:0] logit;
    logic                      start_of_text;

    modport source (output valid, output logit, output start_of_text, input ready);
    modport sink   (input valid, input logit, input start_of_text, output ready);
endinterface

FILE: design/ctcgd_out_if.sv
`timescale 1ns / 1ps
// result channel: one decoded row per transaction
// depends on ctcgd_pkg for field widths

interface ctcgd_out_if
    import ctcgd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               char_valid;
    logic [CHAR_W-1:0]  char_code;
    logic [CLASS_W-1:0] class_index;

    modport source (output valid, output char_valid, output char_code, output class_index,
                    input ready);
    modport sink   (input valid, input char_valid, input char_code, input class_index,
                    output ready);
endinterface

FILE: design/ctcgd_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel carrying the probability threshold
// depends on ctcgd_pkg for the register width

interface ctcgd_cfg_if
    import ctcgd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] prob_threshold;

    modport source (output valid, output prob_threshold, input ready);
    modport sink   (input valid, input prob_threshold, output ready);
endinterface

FILE: design/ctc_greedy_text_decoder_core.sv
`timescale 1ns / 1ps
// sequence: the first score of a row only starts the row in the idle state; any other score
//   goes through accept, exp table lookup and the shared multiply-add; the last score of a row
//   adds the threshold check on the same multiplier, and its result is loaded into the
//   output register. the block takes no new score until it is done with the last one, as
//   the single multiplier and the registered table read are shared; a stalled result holds it.
// reset: synchronous active low, clears the sequencer, counters, threshold and output valid

module ctc_greedy_text_decoder_core
    import ctcgd_pkg::*;
#(
    parameter int CLASSES         = 38,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctcgd_in_if.sink     i_in,
    ctcgd_cfg_if.sink    i_cfg,
    ctcgd_out_if.source  o_out
);

    // only the leading entries of the exp table are nonzero
    localparam int ROM_DEPTH = (EXP_TABLE_DEPTH < EXP_ROM_MAX) ? EXP_TABLE_DEPTH : EXP_ROM_MAX;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int IDX_W     = LOGIT_W - EXP_INDEX_SHIFT;
    localparam int PROD_W    = SUM_W + EXP_W;

    // registers
    t_state                    r_state, n_state;
    logic [THRESH_W-1:0]       r_thresh;
    logic [CLASS_W-1:0]        r_class_counter;
    logic [CLASS_W-1:0]        r_prev_class;
    logic signed [LOGIT_W-1:0] r_running_max;
    logic [CLASS_W-1:0]        r_best_class;
    logic [SUM_W-1:0]          r_exp_sum;
    logic signed [LOGIT_W-1:0] r_x;
    logic [CLASS_W-1:0]        r_cls;
    logic                      r_row_end;
    logic                      r_greater;
    logic [EXP_W-1:0]          r_exp;
    logic                      r_out_valid;
    logic                      r_char_valid;
    logic [CHAR_W-1:0]         r_char_code;
    logic [CLASS_W-1:0]        r_class_index;

    // combinational
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic [CLASS_W-1:0]        w_cls;
    logic                      w_row_end;
    logic                      w_greater;
    logic signed [LOGIT_W:0]   w_diff;
    logic [IDX_W-1:0]          w_idx;
    logic [EXP_W-1:0]          w_exp;
    logic [EXP_W-1:0]          w_rom [ROM_DEPTH];
    logic [EXP_W-1:0]          w_mul_b;
    logic [PROD_W-1:0]         w_prod;
    logic [SUM_W+1:0]          w_sum_full;
    logic [SUM_W-1:0]          w_sum_sat;
    logic                      w_pass;
    logic [CLASS_W-1:0]        w_win;
    logic [CHAR_W-1:0]         w_code;
    logic                      w_emit;

    // constant exp table
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign w_rom[g] = exp_entry(8'(g));
    end

    // handshakes
    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = (r_state == ST_IDLE);
    assign w_in_accept       = i_in.valid && i_in.ready;
    assign w_out_free        = !r_out_valid || o_out.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.char_valid  = r_char_valid;
    assign o_out.char_code   = r_char_code;
    assign o_out.class_index = r_class_index;

    // row position of the incoming score
    assign w_cls     = i_in.start_of_text ? CLASS_BLANK : r_class_counter;
    assign w_row_end = ({1'b0, w_cls} >= 7'(CLASSES - 1));

    // difference to the running maximum and its table entry
    assign w_greater = (r_x > r_running_max);
    assign w_diff    = w_greater ? ({r_x[LOGIT_W-1], r_x} - {r_running_max[LOGIT_W-1], r_running_max})
                                 : ({r_running_max[LOGIT_W-1], r_running_max} - {r_x[LOGIT_W-1], r_x});
    assign w_idx     = w_diff[LOGIT_W-1:EXP_INDEX_SHIFT];
    assign w_exp     = ({4'b0, w_idx} < 16'(ROM_DEPTH)) ? w_rom[w_idx[ROM_AW-1:0]] : '0;

    // shared multiplier: sum rescale, then threshold times sum at row end
    assign w_mul_b = (r_state == ST_THRESH) ? ({1'b0, r_thresh} + 17'd1) : r_exp;
    assign w_prod  = PROD_W'(r_exp_sum) * PROD_W'(w_mul_b);

    // rescaled or accumulated sum with saturation
    assign w_sum_full = r_greater ? (26'(w_prod[PROD_W-1:16]) + 26'(EXP_ONE))
                                  : (26'(r_exp_sum) + 26'(r_exp));
    assign w_sum_sat  = (w_sum_full > 26'(SUM_MAX)) ? SUM_MAX : w_sum_full[SUM_W-1:0];

    // 2^32 / sum > threshold  <=>  (threshold + 1) * sum <= 2^32
    assign w_pass = (r_exp_sum != '0) && (w_prod <= PROD_W'(64'h1_0000_0000));
    assign w_win  = w_pass ? r_best_class : CLASS_BLANK;
    assign w_code = char_of(w_win);
    assign w_emit = (w_win != CLASS_BLANK) && (w_win != r_prev_class) && (w_code != CHAR_SPACE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (w_cls != CLASS_BLANK)) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = r_row_end ? ST_THRESH : ST_IDLE;
            end
            ST_THRESH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_out_load = 1'b0;
        case (r_state)
            ST_THRESH: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_thresh        <= '0;
            r_class_counter <= '0;
            r_prev_class    <= '0;
            r_running_max   <= '0;
            r_best_class    <= '0;
            r_exp_sum       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thresh <= i_cfg.prob_threshold;
            end
            // score transaction: counter, start flag, row start
            if (w_in_accept) begin
                r_class_counter <= w_row_end ? CLASS_BLANK : (w_cls + 6'd1);
                if (i_in.start_of_text) begin
                    r_prev_class <= CLASS_BLANK;
                end
                if (w_cls == CLASS_BLANK) begin
                    r_running_max <= i_in.logit;
                    r_best_class  <= CLASS_BLANK;
                    r_exp_sum     <= SUM_W'(EXP_ONE);
                end
            end
            // online max and sum update
            if (r_state == ST_UPDATE) begin
                r_exp_sum <= w_sum_sat;
                if (r_greater) begin
                    r_running_max <= r_x;
                    r_best_class  <= r_cls;
                end
            end
            // row result
            if (w_out_load) begin
                r_out_valid  <= 1'b1;
                r_prev_class <= w_win;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x       <= i_in.logit;
            r_cls     <= w_cls;
            r_row_end <= w_row_end;
        end
        if (r_state == ST_LOOKUP) begin
            r_greater <= w_greater;
            r_exp     <= w_exp;
        end
        if (w_out_load) begin
            r_char_valid  <= w_emit;
            r_char_code   <= w_emit ? w_code : '0;
            r_class_index <= w_win;
        end
    end

    // a new result only comes from the threshold step
    a_out_from_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == ST_THRESH))
        else $error("result appeared without a threshold step");

    // a row in progress always holds at least exp(0) in its sum
    a_sum_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_exp_sum >= SUM_W'(EXP_ONE)))
        else $error("softmax sum below exp(0) after update");

    // the row position never reaches the class count
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_class_counter} < 7'(CLASSES)))
        else $error("class counter out of range");

endmodule

FILE: sim/tb_ctc_greedy_text_decoder_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the greedy ctc text decoder core: scores go in row by row,
// a scoreboard class predicts each decoded row; depends on ctcgd_pkg and the three interfaces

module tb_ctc_greedy_text_decoder_core;
    import ctcgd_pkg::*;

    localparam int CLASSES         = 38;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int LIMIT_CYCLES    = 600000;

    // one decoded row as it leaves the block
    typedef struct packed {
        logic               char_valid;
        logic [CHAR_W-1:0]  char_code;
        logic [CLASS_W-1:0] class_index;
    } t_row_result;

    // row predictor and the queue of decoded rows still due
    class ctc_row_scoreboard;
        logic [THRESH_W-1:0]        thr;
        logic [CLASS_W-1:0]         col;
        logic signed [LOGIT_W-1:0]  peak;
        logic [CLASS_W-1:0]         peak_cls;
        logic [SUM_W-1:0]           denom;
        logic [CLASS_W-1:0]         last_cls;
        longint unsigned            exp_lut [EXP_TABLE_DEPTH];
        t_row_result                rows_due [$];
        int                         faults;

        function new();
            longint unsigned res;
            longint unsigned base;
            int unsigned     e;
            thr      = '0;
            col      = '0;
            peak     = '0;
            peak_cls = '0;
            denom    = '0;
            last_cls = '0;
            faults   = 0;
            // e^(-i/16) in q1.16, square and multiply in q32 with rounding
            for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
                res  = 64'h1_0000_0000;
                base = EXP_STEP_Q32;
                e    = i;
                while (e != 0) begin
                    if (e[0]) begin
                        res = rnd_q32(res, base);
                    end
                    base = rnd_q32(base, base);
                    e    = e >> 1;
                end
                exp_lut[i] = (res + 64'h8000) >> 16;
            end
        endfunction

        function longint unsigned rnd_q32(longint unsigned a, longint unsigned b);
            return (a * b + 64'h8000_0000) >> 32;
        endfunction

        // table weight of a non-negative q8.8 score difference
        function longint unsigned exp_of(int d);
            int idx;
            idx = (d < 0) ? 0 : (d >>> EXP_INDEX_SHIFT);
            if (idx >= EXP_TABLE_DEPTH) begin
                return 0;
            end
            return exp_lut[idx];
        endfunction

        function logic [CHAR_W-1:0] ascii_of(logic [CLASS_W-1:0] c);
            logic [CHAR_W-1:0] c8;
            c8 = {2'b00, c};
            if (c8 >= 8'd1 && c8 <= 8'd26) begin
                return CHAR_A + (c8 - 8'd1);
            end
            if (c8 >= 8'd27 && c8 <= 8'd35) begin
                return CHAR_ONE + (c8 - 8'd27);
            end
            if (c8 == 8'd36) begin
                return CHAR_ZERO;
            end
            return CHAR_SPACE;
        endfunction

        function void set_threshold(logic [THRESH_W-1:0] v);
            thr = v;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // one accepted score: running max, softmax denominator, row end decision
        function void note_score(logic signed [LOGIT_W-1:0] x, logic sot);
            int unsigned       pos;
            longint unsigned   acc;
            longint unsigned   prob;
            logic [CLASS_W-1:0] win;
            logic [CHAR_W-1:0] code;
            t_row_result       r;
            if (sot) begin
                last_cls = '0;
                col      = '0;
            end
            pos = col;
            if (pos == 0) begin
                peak     = x;
                peak_cls = CLASS_BLANK;
                denom    = SUM_W'(EXP_ONE);
            end else if (x > peak) begin
                acc      = (64'(denom) * exp_of(int'(x) - int'(peak))) >> 16;
                acc      = acc + EXP_ONE;
                denom    = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
                peak     = x;
                peak_cls = pos[CLASS_W-1:0];
            end else begin
                acc   = 64'(denom) + exp_of(int'(peak) - int'(x));
                denom = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
            end
            if (pos + 1 < CLASSES) begin
                col = CLASS_W'(pos + 1);
                return;
            end
            col  = '0;
            prob = (denom == 0) ? 0 : (64'h1_0000_0000 / 64'(denom));
            win  = (prob > 64'(thr)) ? peak_cls : CLASS_BLANK;
            code = ascii_of(win);
            r.char_valid  = (win != CLASS_BLANK) && (win != last_cls) && (code != CHAR_SPACE);
            r.char_code   = r.char_valid ? code : '0;
            r.class_index = win;
            last_cls = win;
            rows_due.push_back(r);
        endfunction

        // compare one decoded row with the oldest prediction
        function void check_row(t_row_result act);
            t_row_result want;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row result, actual %0h", $time, act);
                faults++;
                return;
            end
            want = rows_due.pop_front();
            if (act.char_valid !== want.char_valid) begin
                $display("%0t: char_valid mismatch, expected %0d actual %0d",
                         $time, want.char_valid, act.char_valid);
                faults++;
            end
            if (act.char_code !== want.char_code) begin
                $display("%0t: char_code mismatch, expected %0h actual %0h",
                         $time, want.char_code, act.char_code);
                faults++;
            end
            if (act.class_index !== want.class_index) begin
                $display("%0t: class_index mismatch, expected %0d actual %0d",
                         $time, want.class_index, act.class_index);
                faults++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ctcgd_in_if  in_if ();
    ctcgd_cfg_if cfg_if ();
    ctcgd_out_if out_if ();

    ctc_greedy_text_decoder_core #(
        .CLASSES         (CLASSES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    ctc_row_scoreboard sb = new();

    logic signed [LOGIT_W-1:0] row_buf [CLASSES];
    int  burst_left = 0;
    int  items_sent = 0;
    int  last_pick  = -1;
    bit  tx_free    = 0;
    bit  rx_free    = 0;
    bit  need_sot   = 1;
    int  cycles     = 0;
    int  seg_left   = 0;
    bit  seg_ready  = 1;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // known values on every input from the start
    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.logit           = '0;
        in_if.start_of_text   = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.prob_threshold = '0;
        out_if.ready          = 1'b0;
    end

    // receiver stall pattern: ready and stalled segments of random length, always ready while rx_free is set
    always @(negedge i_clk) begin
        if (seg_left == 0) begin
            if (rx_free) begin
                seg_ready = 1'b1;
                seg_left  = 16;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        seg_ready = 1'b1;
                        seg_left  = $urandom_range(1, 12);
                    end
                    6, 7, 8: begin
                        seg_ready = 1'b0;
                        seg_left  = $urandom_range(1, 4);
                    end
                    default: begin
                        seg_ready = 1'b0;
                        seg_left  = $urandom_range(10, 30);
                    end
                endcase
            end
        end
        out_if.ready = seg_ready;
        seg_left     = seg_left - 1;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_row('{out_if.char_valid, out_if.char_code, out_if.class_index});
        end
    end

    // run limit
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("ctc_greedy_text_decoder_core regression: fail");
        $finish;
    end

    // one score transaction
    task automatic send_score(input logic signed [LOGIT_W-1:0] x, input logic sot);
        @(negedge i_clk);
        in_if.valid         = 1'b1;
        in_if.logit         = x;
        in_if.start_of_text = sot;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_score(x, sot);
        items_sent++;
    endtask

    task automatic idle_in(input int n);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // sender bursts with random gaps, no gaps while tx_free is set
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (!tx_free) begin
                idle_in($urandom_range(1, 7));
            end
        end
    endtask

    task automatic push_row(input int n, input bit sot);
        for (int i = 0; i < n; i++) begin
            send_score(row_buf[i], sot && (i == 0));
            pace();
        end
    endtask

    // hold the sender until every predicted row has come out
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid          = 1'b1;
        cfg_if.prob_threshold = v;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_threshold(v);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic fill_row(input int v);
        for (int i = 0; i < CLASSES; i++) begin
            row_buf[i] = LOGIT_W'(v);
        end
    endtask

    // random row content: full range, peaked, flat or ramp
    task automatic fill_random_row();
        int win;
        int center;
        int spread;
        int margin;
        int slope;
        if (last_pick >= 0 && $urandom_range(0, 3) == 0) begin
            win = last_pick;
        end else begin
            win = $urandom_range(0, CLASSES - 1);
        end
        last_pick = win;
        center = $urandom_range(0, 40000) - 20000;
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int i = 0; i < CLASSES; i++) begin
                    row_buf[i] = LOGIT_W'($urandom);
                end
            end
            2, 3, 4, 5: begin
                spread = $urandom_range(0, 4000);
                margin = $urandom_range(0, 9000);
                for (int i = 0; i < CLASSES; i++) begin
                    row_buf[i] = LOGIT_W'(center - spread / 2 + $urandom_range(0, spread));
                end
                row_buf[win] = LOGIT_W'(center + spread / 2 + margin);
            end
            6, 7: begin
                for (int i = 0; i < CLASSES; i++) begin
                    row_buf[i] = LOGIT_W'(center + 16 * $urandom_range(0, 2));
                end
            end
            default: begin
                slope = $urandom_range(0, 400) - 200;
                for (int i = 0; i < CLASSES; i++) begin
                    row_buf[i] = LOGIT_W'(center / 2 + i * slope);
                end
            end
        endcase
    endtask

    task automatic random_rows(input int quota);
        int stop_at;
        int n;
        bit sot;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            fill_random_row();
            sot = need_sot || ($urandom_range(0, 6) == 0);
            // a broken row now and then, cut short and restarted by a new text line
            if ($urandom_range(0, 11) == 0) begin
                n        = $urandom_range(1, CLASSES - 1);
                need_sot = 1;
            end else begin
                n        = CLASSES;
                need_sot = 0;
            end
            push_row(n, sot);
        end
    endtask

    // stimulus
    initial begin
        logic [THRESH_W-1:0] thr_plan [6];
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_threshold('0);

        // flat row: every class ties, blank wins
        fill_row(0);
        push_row(CLASSES, 1'b1);
        // extreme peak on class 1 against the most negative score
        fill_row(-32768);
        row_buf[1] = 16'sh7FFF;
        push_row(CLASSES, 1'b0);
        // same winner again is a repeat and emits nothing
        push_row(CLASSES, 1'b0);
        // tie between class 3 and class 20 keeps the earliest
        fill_row(100);
        row_buf[3]  = 16'sd2000;
        row_buf[20] = 16'sd2000;
        push_row(CLASSES, 1'b0);
        // rising ramp, every score a new max, ends on a space class
        for (int i = 0; i < CLASSES; i++) begin
            row_buf[i] = LOGIT_W'(-300 + 16 * i);
        end
        push_row(CLASSES, 1'b0);
        // differences right at the edge of the exp table
        fill_row(0);
        row_buf[0]  = 16'sd4096;
        row_buf[1]  = 16'sd4097;
        row_buf[36] = 16'sd8192;
        push_row(CLASSES, 1'b0);
        // broken row, then a new text line clears the previous class
        fill_row(-500);
        row_buf[26] = 16'sd9000;
        push_row(10, 1'b0);
        push_row(CLASSES, 1'b1);
        push_row(CLASSES, 1'b1);
        drain();

        // highest threshold: only a certain winner passes
        write_threshold(16'hFFFF);
        fill_row(-32768);
        row_buf[5] = 16'sh7FFF;
        push_row(CLASSES, 1'b1);
        row_buf[0] = 16'sh7F00;
        push_row(CLASSES, 1'b1);
        drain();

        thr_plan[0] = '0;
        thr_plan[1] = 16'hFFFF;
        thr_plan[2] = THRESH_W'($urandom_range(0, 65535));
        thr_plan[3] = 16'h8000;
        thr_plan[4] = 16'h0001;
        thr_plan[5] = THRESH_W'($urandom_range(40000, 65534));
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_plan[p]);
            tx_free = (p == 1);
            rx_free = (p == 1);
            random_rows(95);
            if (p == 3) begin
                drain();
            end
            random_rows(95);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("ctc_greedy_text_decoder_core regression: pass");
        end else begin
            $display("ctc_greedy_text_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
